// ===== rtl/core/julia_escape_time_pixel_top_assert.svh =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel assertion macros
// Shared property forms for the controller checks.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define JETP_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("julia pixel check failed");

// Condition implies consequence in the next cycle.
`define JETP_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("julia pixel check failed");

`endif

// ===== rtl/core/jetp_pkg.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel package
// Payload types, register indexes, controller codes and color constants.
// ----------------------------------------------------------------------------
package jetp_pkg;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic [31:0] pixel_argb;
        logic [10:0] iteration_count;
        logic        bounded;
    } out_t;

    localparam logic [2:0] CFG_REAL_START = 3'd0;
    localparam logic [2:0] CFG_IMAG_START = 3'd1;
    localparam logic [2:0] CFG_REAL_STEP  = 3'd2;
    localparam logic [2:0] CFG_IMAG_STEP  = 3'd3;
    localparam logic [2:0] CFG_C_REAL     = 3'd4;
    localparam logic [2:0] CFG_C_IMAG     = 3'd5;
    localparam logic [2:0] CFG_MAX_ITER   = 3'd6;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_MUL,
        OP_ITER,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CH_START,
        OP_CHUNK,
        OP_CH_STORE
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_MUL,
        S_ITER,
        S_DIV_INIT,
        S_DIV,
        S_CH_START,
        S_CHUNK,
        S_CH_STORE,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] chunk;
        logic [1:0] fac;
        logic [1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic stop;
        logic bounded;
    } status_t;

    // Channel scale: 9*255, 15*255 and 17*255 (blue takes one extra shift).
    function automatic logic [12:0] chan_k(input logic [1:0] ch);
        case (ch)
            CH_RED:   chan_k = 13'd2295;
            CH_GREEN: chan_k = 13'd3825;
            default:  chan_k = 13'd4335;
        endcase
    endfunction

    // Red takes u t t t, green u u t t, blue u u u t.
    function automatic logic factor_is_u(input logic [1:0] ch, input logic [1:0] fac);
        case (ch)
            CH_RED:   factor_is_u = (fac == 2'd0);
            CH_GREEN: factor_is_u = (fac <= 2'd1);
            default:  factor_is_u = (fac <= 2'd2);
        endcase
    endfunction

    function automatic logic signed [31:0] sat_q28(input logic signed [43:0] v);
        if (v[43:31] == {13{v[43]}})
        begin
            sat_q28 = v[31:0];
        end
        else if (v[43])
        begin
            sat_q28 = 32'sh8000_0000;
        end
        else
        begin
            sat_q28 = 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

// ===== rtl/core/julia_escape_time_pixel_top.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel renderer
// Maps one pixel to a Julia set point, counts escape iterations and colors it.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and must be captured then, as
// the receiver cannot stall the block. One pixel is in flight at a time. A
// pixel that runs N iterations spends each iteration in one multiply step
// and one update step of the iteration unit; a pixel that escapes then
// also passes through a bit-serial divider and, for each channel, the
// shared color multiplier. Configuration writes are always ready and are
// registered.
module julia_escape_time_pixel_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  jetp_pkg::in_t   pixel,
    output logic            done,
    output jetp_pkg::out_t  result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    jetp_pkg::cmd_t    cmd;
    jetp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    jetp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    jetp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pixel     (pixel),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result)
    );

endmodule

// ===== rtl/core/jetp_datapath.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel datapath
// Configuration registers, iteration unit, divider and color multiplier.
// ----------------------------------------------------------------------------
module jetp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  jetp_pkg::cmd_t     cmd,
    input  jetp_pkg::in_t      pixel,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output jetp_pkg::status_t  status,
    output jetp_pkg::out_t     result
);

    logic signed [31:0] real_start_reg, imag_start_reg, real_step_reg, imag_step_reg;
    logic signed [31:0] c_real_reg, c_imag_reg;
    logic [10:0]        limit_reg;

    logic signed [42:0] mx_reg, my_reg;
    logic signed [31:0] zr_reg, zi_reg;
    logic signed [63:0] rr_reg, ii_reg, ri_reg;
    logic [10:0]        count_reg;
    logic               bnd_reg;
    logic [11:0]        rem_reg;
    logic [15:0]        t_reg;
    logic [79:0]        x_reg, p_reg;
    logic [7:0]         r_reg, g_reg, b_reg;

    logic [64:0]        mag;
    logic               escape;
    logic signed [63:0] dr, ri2;
    logic signed [43:0] nr, ni;
    logic [11:0]        rem2;
    logic [16:0]        u, f;
    logic [31:0]        xs;
    logic [48:0]        prod;
    logic [79:0]        ext;
    logic [7:0]         chan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_start_reg <= -32'sd536870912;
            imag_start_reg <= -32'sd536870912;
            real_step_reg  <= 32'sd1342177;
            imag_step_reg  <= 32'sd1342177;
            c_real_reg     <= -32'sd187904819;
            c_imag_reg     <= 32'sd72517838;
            limit_reg      <= 11'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jetp_pkg::CFG_REAL_START: real_start_reg <= cfg_data;
                jetp_pkg::CFG_IMAG_START: imag_start_reg <= cfg_data;
                jetp_pkg::CFG_REAL_STEP:  real_step_reg  <= cfg_data;
                jetp_pkg::CFG_IMAG_STEP:  imag_step_reg  <= cfg_data;
                jetp_pkg::CFG_C_REAL:     c_real_reg     <= cfg_data;
                jetp_pkg::CFG_C_IMAG:     c_imag_reg     <= cfg_data;
                jetp_pkg::CFG_MAX_ITER:   limit_reg      <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // The squares are never negative, so the magnitude fits unsigned in 65 bits.
    assign mag    = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign escape = (mag[64:58] != 7'd0);
    assign dr     = rr_reg - ii_reg;
    assign ri2    = {ri_reg[62:0], 1'b0};
    assign nr     = 44'($signed(dr[63:28])) + 44'(c_real_reg);
    assign ni     = 44'($signed(ri2[63:28])) + 44'(c_imag_reg);

    assign status.stop    = (count_reg >= limit_reg) || escape;
    assign status.bounded = (count_reg == limit_reg);

    assign rem2 = {rem_reg[10:0], 1'b0};
    assign u    = 17'd65536 - {1'b0, t_reg};
    assign f    = jetp_pkg::factor_is_u(cmd.ch, cmd.fac) ? u : {1'b0, t_reg};

    always_comb
    begin
        case (cmd.chunk)
            2'd0:    xs = x_reg[31:0];
            2'd1:    xs = x_reg[63:32];
            default: xs = {16'd0, x_reg[79:64]};
        endcase
        prod = {17'd0, xs} * {32'd0, f};
        case (cmd.chunk)
            2'd0:    ext = {31'd0, prod};
            2'd1:    ext = {prod[47:0], 32'd0};
            default: ext = {prod[15:0], 64'd0};
        endcase
        if (cmd.ch == jetp_pkg::CH_BLUE)
        begin
            chan = (x_reg[79:73] != 7'd0) ? 8'hFF : x_reg[72:65];
        end
        else
        begin
            chan = (x_reg[79:72] != 8'd0) ? 8'hFF : x_reg[71:64];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            jetp_pkg::OP_LOAD:
            begin
                mx_reg <= $signed({1'b0, pixel.pixel_x}) * real_step_reg;
                my_reg <= $signed({1'b0, pixel.pixel_y}) * imag_step_reg;
            end
            jetp_pkg::OP_INIT:
            begin
                zr_reg    <= jetp_pkg::sat_q28(44'(real_start_reg) + 44'(mx_reg));
                zi_reg    <= jetp_pkg::sat_q28(44'(imag_start_reg) + 44'(my_reg));
                count_reg <= 11'd0;
            end
            jetp_pkg::OP_MUL:
            begin
                rr_reg <= zr_reg * zr_reg;
                ii_reg <= zi_reg * zi_reg;
                ri_reg <= zr_reg * zi_reg;
            end
            jetp_pkg::OP_ITER:
            begin
                if (status.stop)
                begin
                    bnd_reg <= status.bounded;
                    r_reg   <= 8'd0;
                    g_reg   <= 8'd0;
                    b_reg   <= 8'd0;
                end
                else
                begin
                    zr_reg    <= jetp_pkg::sat_q28(nr);
                    zi_reg    <= jetp_pkg::sat_q28(ni);
                    count_reg <= count_reg + 11'd1;
                end
            end
            jetp_pkg::OP_DIV_INIT:
            begin
                rem_reg <= {1'b0, count_reg};
                t_reg   <= 16'd0;
            end
            jetp_pkg::OP_DIV_STEP:
            begin
                if (rem2 >= {1'b0, limit_reg})
                begin
                    rem_reg <= rem2 - {1'b0, limit_reg};
                    t_reg   <= {t_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2;
                    t_reg   <= {t_reg[14:0], 1'b0};
                end
            end
            jetp_pkg::OP_CH_START:
            begin
                x_reg <= {67'd0, jetp_pkg::chan_k(cmd.ch)};
            end
            jetp_pkg::OP_CHUNK:
            begin
                case (cmd.chunk)
                    2'd0:    p_reg <= ext;
                    2'd1:    p_reg <= p_reg + ext;
                    default: x_reg <= p_reg + ext;
                endcase
            end
            jetp_pkg::OP_CH_STORE:
            begin
                case (cmd.ch)
                    jetp_pkg::CH_RED:   r_reg <= chan;
                    jetp_pkg::CH_GREEN: g_reg <= chan;
                    default:            b_reg <= chan;
                endcase
            end
            default: ;
        endcase
    end

    assign result.pixel_argb      = {8'hFF, r_reg, g_reg, b_reg};
    assign result.iteration_count = count_reg;
    assign result.bounded         = bnd_reg;

endmodule

// ===== rtl/core/jetp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Julia escape-time pixel controller
// Sequences iteration, division and the three color products.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_top_assert.svh"

module jetp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  jetp_pkg::status_t  status,
    output jetp_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               done
);

    jetp_pkg::state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] chunk_reg, chunk_next;
    logic [1:0] fac_reg, fac_next;
    logic [1:0] ch_reg, ch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jetp_pkg::S_IDLE;
            step_reg  <= 4'd0;
            chunk_reg <= 2'd0;
            fac_reg   <= 2'd0;
            ch_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            chunk_reg <= chunk_next;
            fac_reg   <= fac_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        chunk_next = chunk_reg;
        fac_next   = fac_reg;
        ch_next    = ch_reg;
        cmd.op     = jetp_pkg::OP_NOP;
        cmd.chunk  = chunk_reg;
        cmd.fac    = fac_reg;
        cmd.ch     = ch_reg;
        case (state_reg)
            jetp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = jetp_pkg::OP_LOAD;
                    state_next = jetp_pkg::S_INIT;
                end
            end
            jetp_pkg::S_INIT:
            begin
                cmd.op     = jetp_pkg::OP_INIT;
                state_next = jetp_pkg::S_MUL;
            end
            jetp_pkg::S_MUL:
            begin
                cmd.op     = jetp_pkg::OP_MUL;
                state_next = jetp_pkg::S_ITER;
            end
            jetp_pkg::S_ITER:
            begin
                cmd.op = jetp_pkg::OP_ITER;
                if (!status.stop)
                begin
                    state_next = jetp_pkg::S_MUL;
                end
                else if (status.bounded)
                begin
                    state_next = jetp_pkg::S_DONE;
                end
                else
                begin
                    state_next = jetp_pkg::S_DIV_INIT;
                end
            end
            jetp_pkg::S_DIV_INIT:
            begin
                cmd.op     = jetp_pkg::OP_DIV_INIT;
                step_next  = 4'd0;
                state_next = jetp_pkg::S_DIV;
            end
            jetp_pkg::S_DIV:
            begin
                cmd.op    = jetp_pkg::OP_DIV_STEP;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    ch_next    = jetp_pkg::CH_RED;
                    state_next = jetp_pkg::S_CH_START;
                end
            end
            jetp_pkg::S_CH_START:
            begin
                cmd.op     = jetp_pkg::OP_CH_START;
                chunk_next = 2'd0;
                fac_next   = 2'd0;
                state_next = jetp_pkg::S_CHUNK;
            end
            jetp_pkg::S_CHUNK:
            begin
                cmd.op = jetp_pkg::OP_CHUNK;
                if (chunk_reg == 2'd2)
                begin
                    chunk_next = 2'd0;
                    fac_next   = fac_reg + 2'd1;
                    if (fac_reg == 2'd3)
                    begin
                        state_next = jetp_pkg::S_CH_STORE;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + 2'd1;
                end
            end
            jetp_pkg::S_CH_STORE:
            begin
                cmd.op  = jetp_pkg::OP_CH_STORE;
                ch_next = ch_reg + 2'd1;
                if (ch_reg == jetp_pkg::CH_BLUE)
                begin
                    state_next = jetp_pkg::S_DONE;
                end
                else
                begin
                    state_next = jetp_pkg::S_CH_START;
                end
            end
            jetp_pkg::S_DONE:
            begin
                state_next = jetp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = jetp_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != jetp_pkg::S_IDLE);
    assign done = (state_reg == jetp_pkg::S_DONE);

    `JETP_ASSERT_NEXT(a_done_single, done, !done)
    `JETP_ASSERT_NEXT(a_done_then_idle, done, !busy)
    `JETP_ASSERT_NEXT(a_accept_no_early_done, start && !busy, busy && !done)
    `JETP_ASSERT_SAME(a_chunk_range, state_reg == jetp_pkg::S_CHUNK, chunk_reg != 2'd3)

endmodule
